// File: sv/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
// No dependencies; used by bba_ctrl, the top level, the checker and the testbench.
package bba_pkg;

    // Field widths of the request and result words
    localparam int KIND_W = 2;
    localparam int IDX_W  = 12;
    localparam int CNT_W  = 13;

    // Default map geometry: 128 words of 32 bits, 4096 blocks
    localparam int MAP_WORDS_DEF = 128;
    localparam int WORD_BITS_DEF = 32;

    // Reset value of the reserved-block register
    localparam logic [CNT_W-1:0] RESERVED_RST = 13'd33;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_MARK   = 2'd1,
        KIND_FORMAT = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

endpackage

// File: sv/bba_map_ram.sv
// Bitmap storage: simple dual-port synchronous RAM with a registered read port.
// No dependencies.
module bba_map_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: sv/bba_ctrl.sv
// Request sequencer: scans, modifies and writes back map words, keeps the
// free count and the reserved register. Depends on bba_pkg; drives bba_map_ram.
module bba_ctrl #(
    parameter int MAP_WORDS = 128,
    parameter int WORD_BITS = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    output logic                                    o_busy,
    input  logic [bba_pkg::KIND_W-1:0]              i_kind,
    input  logic [bba_pkg::IDX_W-1:0]               i_block_index,
    input  logic                                    i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0]               i_cfg_wdata,
    output logic                                    o_done,
    output logic [bba_pkg::IDX_W-1:0]               o_result_index,
    output logic                                    o_ok,
    output logic [bba_pkg::CNT_W-1:0]               o_free_count,
    // map RAM side
    output logic                                    o_ram_we,
    output logic [(MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1)-1:0] o_ram_waddr,
    output logic [WORD_BITS-1:0]                    o_ram_wdata,
    output logic                                    o_ram_re,
    output logic [(MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1)-1:0] o_ram_raddr,
    input  logic [WORD_BITS-1:0]                    i_ram_rdata
);
    import bba_pkg::*;

    localparam int TOTAL = MAP_WORDS * WORD_BITS;
    localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int CW    = $clog2(TOTAL + 1);
    localparam int EW    = ((CW > CNT_W) ? CW : CNT_W) + 1;

    localparam logic [EW-1:0]        TOTAL_E = EW'(TOTAL);
    localparam logic [EW-1:0]        WB_E    = EW'(WORD_BITS);
    localparam logic [AW-1:0]        LAST    = AW'(MAP_WORDS - 1);
    localparam logic [WORD_BITS-1:0] ONES    = '1;
    localparam logic [WORD_BITS-1:0] LSB     = WORD_BITS'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_SEEK,
        S_MARK,
        S_FILL
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic [EW-1:0]       r_base, n_base;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pend_addr, n_pend_addr;
    logic [EW-1:0]       r_pend_base, n_pend_base;
    logic                r_last_issued, n_last_issued;
    logic [EW-1:0]       r_blk, n_blk;
    logic [BW-1:0]       r_bit, n_bit;
    logic [EW-1:0]       r_nres, n_nres;
    logic                r_fmt, n_fmt;
    logic [CW-1:0]       r_free, n_free;
    logic [CNT_W-1:0]    r_reserved, n_reserved;
    logic                r_done, n_done;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_ok, n_ok;

    logic [BW-1:0]        zpos;
    logic                 zany;
    logic [EW-1:0]        blk_ext;
    logic [EW-1:0]        res_ext;
    logic [EW-1:0]        nres_clamp;
    logic [EW-1:0]        rem;
    logic [WORD_BITS-1:0] fill_word;
    logic [EW-1:0]        base_next;
    logic [EW-1:0]        blk_off;
    logic [EW-1:0]        alloc_idx;
    logic [CW-1:0]        free_dec;

    // Lowest clear bit of the word just read
    always_comb begin
        zpos = '0;
        zany = 1'b0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!i_ram_rdata[i]) begin
                zpos = BW'(i);
                zany = 1'b1;
            end
        end
    end

    // Datapath helpers
    always_comb begin
        blk_ext    = EW'(i_block_index);
        res_ext    = EW'(r_reserved);
        nres_clamp = (res_ext > TOTAL_E) ? TOTAL_E : res_ext;
        rem        = r_nres - r_base;
        if (r_nres <= r_base) begin
            fill_word = '0;
        end else if (rem >= WB_E) begin
            fill_word = ONES;
        end else begin
            fill_word = ~(ONES << rem[BW-1:0]);
        end
        base_next = r_base + WB_E;
        blk_off   = r_blk - r_base;
        alloc_idx = r_pend_base + EW'(zpos);
        free_dec  = (r_free != '0) ? (r_free - CW'(1)) : r_free;
    end

    // Next-state logic
    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_base        = r_base;
        n_pend        = r_pend;
        n_pend_addr   = r_pend_addr;
        n_pend_base   = r_pend_base;
        n_last_issued = r_last_issued;
        n_blk         = r_blk;
        n_bit         = r_bit;
        n_nres        = r_nres;
        n_fmt         = r_fmt;
        n_free        = r_free;
        n_reserved    = i_cfg_we ? i_cfg_wdata : r_reserved;
        n_done        = 1'b0;
        n_idx         = r_idx;
        n_ok          = r_ok;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_addr;
        o_ram_wdata = fill_word;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_addr;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_addr = '0;
                    n_base = '0;
                    case (t_kind'(i_kind))
                        KIND_ALLOC: begin
                            n_state       = S_ALLOC;
                            n_pend        = 1'b0;
                            n_last_issued = 1'b0;
                        end
                        KIND_MARK: begin
                            if (blk_ext < TOTAL_E) begin
                                n_state = S_SEEK;
                                n_blk   = blk_ext;
                            end else begin
                                // block beyond the map: echoed, not stored
                                n_done = 1'b1;
                                n_idx  = i_block_index;
                                n_ok   = 1'b0;
                            end
                        end
                        KIND_FORMAT: begin
                            n_state = S_FILL;
                            n_nres  = nres_clamp;
                            n_fmt   = 1'b1;
                            n_free  = CW'(TOTAL_E - nres_clamp);
                        end
                        default: begin
                            n_done = 1'b1;
                            n_idx  = '0;
                            n_ok   = 1'b0;
                        end
                    endcase
                end
            end

            // Rewrite every word; reserved leading blocks come out set
            S_FILL: begin
                o_ram_we = 1'b1;
                if (r_addr == LAST) begin
                    n_state = S_IDLE;
                    n_done  = r_fmt;
                    n_idx   = '0;
                    n_ok    = 1'b1;
                end else begin
                    n_addr = r_addr + AW'(1);
                    n_base = base_next;
                end
            end

            // One read issued per cycle, the word read last cycle checked
            S_ALLOC: begin
                o_ram_re = !r_last_issued;
                if (!r_last_issued) begin
                    n_pend        = 1'b1;
                    n_pend_addr   = r_addr;
                    n_pend_base   = r_base;
                    n_addr        = r_addr + AW'(1);
                    n_base        = base_next;
                    n_last_issued = (r_addr == LAST);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend && zany) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_pend_addr;
                    o_ram_wdata = i_ram_rdata | (LSB << zpos);
                    n_free      = free_dec;
                    n_state     = S_IDLE;
                    n_done      = 1'b1;
                    n_idx       = alloc_idx[IDX_W-1:0];
                    n_ok        = 1'b1;
                end else if (r_pend && (r_pend_addr == LAST)) begin
                    // map full
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_idx   = '0;
                    n_ok    = 1'b0;
                end
            end

            // Walk word bases up to the one that holds the block
            S_SEEK: begin
                if (r_blk < base_next) begin
                    o_ram_re = 1'b1;
                    n_bit    = blk_off[BW-1:0];
                    n_state  = S_MARK;
                end else begin
                    n_addr = r_addr + AW'(1);
                    n_base = base_next;
                end
            end

            // Set the bit if clear; count drops only then
            S_MARK: begin
                if (!i_ram_rdata[r_bit]) begin
                    o_ram_we    = 1'b1;
                    o_ram_wdata = i_ram_rdata | (LSB << r_bit);
                    n_free      = free_dec;
                end
                n_state = S_IDLE;
                n_done  = 1'b1;
                n_idx   = r_blk[IDX_W-1:0];
                n_ok    = 1'b1;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs; reset starts a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_FILL;
            r_addr        <= '0;
            r_base        <= '0;
            r_pend        <= 1'b0;
            r_last_issued <= 1'b0;
            r_nres        <= '0;
            r_fmt         <= 1'b0;
            r_free        <= CW'(TOTAL);
            r_reserved    <= RESERVED_RST;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_addr        <= n_addr;
            r_base        <= n_base;
            r_pend        <= n_pend;
            r_last_issued <= n_last_issued;
            r_nres        <= n_nres;
            r_fmt         <= n_fmt;
            r_free        <= n_free;
            r_reserved    <= n_reserved;
            r_done        <= n_done;
            r_pend_addr   <= n_pend_addr;
            r_pend_base   <= n_pend_base;
            r_blk         <= n_blk;
            r_bit         <= n_bit;
            r_idx         <= n_idx;
            r_ok          <= n_ok;
        end
    end

    logic [EW-1:0] free_ext;
    assign free_ext = EW'(r_free);

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_result_index = r_idx;
    assign o_ok           = r_ok;
    assign o_free_count   = free_ext[CNT_W-1:0];

endmodule

// File: sv/block_bitmap_allocator_unit.sv
// Top level of the block bitmap allocator: sequencer plus bitmap RAM.
// Depends on bba_pkg, bba_map_ram and bba_ctrl.
//
// Usage: drive i_kind and i_block_index and raise start while busy is low;
// the word is taken at that clock edge. Exactly one result word follows,
// shown on o_result_index, o_ok and o_free_count for one cycle with o_done
// high. The receiver cannot stall; results must be taken when o_done is up.
// Per kind: allocate reads one map word per cycle and the first non-full
// word wins; mark walks the word addresses, then does a read-modify-write;
// format rewrites one word per cycle; an unused kind or a mark beyond the
// map is answered straight from idle, with no map access.
// At the defaults an allocate on a full map walks all 128 map words through
// the single RAM read port.
// i_cfg_we/i_cfg_wdata write the reserved-block count used by format; write
// only while busy is low and no result is pending.
// After reset the block clears the map, one word per cycle: busy stays high
// for the whole pass and no result is given for that pass.
module block_bitmap_allocator_unit #(
    parameter int MAP_WORDS = bba_pkg::MAP_WORDS_DEF,
    parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bba_pkg::KIND_W-1:0]  i_kind,
    input  logic [bba_pkg::IDX_W-1:0]   i_block_index,
    input  logic                        i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0]   i_cfg_wdata,
    output logic                        o_done,
    output logic [bba_pkg::IDX_W-1:0]   o_result_index,
    output logic                        o_ok,
    output logic [bba_pkg::CNT_W-1:0]   o_free_count
);
    import bba_pkg::*;

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // Request sequencer and free count
    bba_ctrl #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_kind         (i_kind),
        .i_block_index  (i_block_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_result_index (o_result_index),
        .o_ok           (o_ok),
        .o_free_count   (o_free_count),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata)
    );

    // Used-block bitmap
    bba_map_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// File: sv/bba_chk.sv
// Port-level checker for block_bitmap_allocator_unit, bound to the top level.
// Depends on bba_pkg.
module bba_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic [bba_pkg::CNT_W-1:0]   o_free_count
);
    import bba_pkg::*;

    // Reset always launches the map clearing pass
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // An accepted word either starts work or answers at once
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted word neither busy nor answered");

    // A result is given only once the work is done
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while still busy");

    // Back-to-back results need a fresh word in between
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done)) |-> $past(start && !busy))
        else $error("extra result without a request");

    // Free count shown with a result never exceeds the default map size
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_free_count <= 13'd4096))
        else $error("free count out of range");

endmodule

bind block_bitmap_allocator_unit bba_chk u_bba_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_free_count (o_free_count)
);

// File: dv/tb.sv
// Self-checking testbench for block_bitmap_allocator_unit (first-fit block bitmap).
// Depends on bba_pkg and the RTL of the block; a scoreboard class predicts every
// result word from its own copy of the bitmap, free count and reserved count.
`timescale 1ns / 1ps

import bba_pkg::*;

// Scoreboard: mirrors the used-block map and predicts the result word of each request
class bitmap_scoreboard;
    localparam int TOTAL_BLOCKS = MAP_WORDS_DEF * WORD_BITS_DEF;

    typedef struct packed {
        logic [IDX_W-1:0] block;
        logic             ok;
        logic [CNT_W-1:0] free_count;
    } t_result;

    logic [WORD_BITS_DEF-1:0] used_map [MAP_WORDS_DEF];
    logic [CNT_W-1:0]         free_blocks;
    logic [CNT_W-1:0]         reserved;
    t_result                  pending_results [$];
    int                       errors;
    int                       results_seen;
    int                       full_refusals;
    int                       kind_seen [4];

    function new();
        clear_map();
        reserved = RESERVED_RST;
        errors = 0;
        results_seen = 0;
        full_refusals = 0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void clear_map();
        foreach (used_map[w]) used_map[w] = '0;
        free_blocks = CNT_W'(TOTAL_BLOCKS);
    endfunction

    function bit is_used(int blk);
        return used_map[blk / WORD_BITS_DEF][blk % WORD_BITS_DEF];
    endfunction

    // Count drops only on a clear-to-set transition
    function void claim_block(int blk);
        if (!is_used(blk)) begin
            used_map[blk / WORD_BITS_DEF][blk % WORD_BITS_DEF] = 1'b1;
            if (free_blocks != 0) free_blocks--;
        end
    endfunction

    // Accepted request word: update the mirror and queue the expected result word
    function void note_request(t_kind kind, logic [IDX_W-1:0] blk);
        t_result r;
        int      b;
        int      n;
        r = '0;
        kind_seen[int'(kind)]++;
        case (kind)
            KIND_ALLOC: begin
                for (b = 0; b < TOTAL_BLOCKS; b++) begin
                    if (!is_used(b)) break;
                end
                if (b < TOTAL_BLOCKS) begin
                    claim_block(b);
                    r.block = IDX_W'(b);
                    r.ok    = 1'b1;
                end else begin
                    full_refusals++;
                end
            end
            KIND_MARK: begin
                r.block = blk;
                if (int'(blk) < TOTAL_BLOCKS) begin
                    claim_block(int'(blk));
                    r.ok = 1'b1;
                end
            end
            KIND_FORMAT: begin
                // reserved count saturates at the map size
                n = (int'(reserved) > TOTAL_BLOCKS) ? TOTAL_BLOCKS : int'(reserved);
                clear_map();
                for (b = 0; b < n; b++) claim_block(b);
                r.ok = 1'b1;
            end
            default: ;  // unused kind: nothing changes
        endcase
        r.free_count = free_blocks;
        pending_results.push_back(r);
    endfunction

    task report(string what, int got, int want);
        errors++;
        if (errors <= 40)
            $display("mismatch at result %0d: %s: got %0d, expected %0d",
                     results_seen, what, got, want);
    endtask

    task check_result(logic [IDX_W-1:0] blk, logic ok, logic [CNT_W-1:0] free_count);
        t_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            report("result word with no request pending", int'(blk), 0);
        end else begin
            want = pending_results.pop_front();
            if (blk !== want.block)
                report("result_index", int'(blk), int'(want.block));
            if (ok !== want.ok)
                report("ok", int'(ok), int'(want.ok));
            if (free_count !== want.free_count)
                report("free_count", int'(free_count), int'(want.free_count));
        end
    endtask
endclass

module tb;
    localparam int RESET_CYCLES = 9;
    localparam int QUIET_LIMIT  = 4000;   // reset clear pass + slowest word + gap, several times
    localparam int DRAIN_CYCLES = 140;    // covers the longest item at the defaults
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 150;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic [KIND_W-1:0]  i_kind        = KIND_ALLOC;
    logic [IDX_W-1:0]   i_block_index = '0;
    logic               i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata   = '0;
    logic               busy;
    logic               o_done;
    logic [IDX_W-1:0]   o_result_index;
    logic               o_ok;
    logic [CNT_W-1:0]   o_free_count;

    bitmap_scoreboard sb = new();
    bit               burst = 1'b0;   // no sender gaps while set
    int               settings_used = 0;

    block_bitmap_allocator_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_block_index  (i_block_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_result_index (o_result_index),
        .o_ok           (o_ok),
        .o_free_count   (o_free_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Monitor: check a finished word before noting a new one taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1)
                sb.check_result(o_result_index, o_ok, o_free_count);
            if (start && busy === 1'b0)
                sb.note_request(t_kind'(i_kind), i_block_index);
        end
    end

    // Watchdog: ends the run after too many cycles with no handshake
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((start && busy === 1'b0) || o_done === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Present one request word after a random gap (none in burst); returns at the accepting edge
    task automatic send_word(t_kind kind, logic [IDX_W-1:0] blk);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_kind        <= kind;
        i_block_index <= blk;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Hold off until every result word is in and the block is idle
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (sb.pending_results.size() != 0 || busy !== 1'b0);
        @(posedge i_clk);
    endtask

    task automatic write_reserved(logic [CNT_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.reserved = value;
        settings_used++;
    endtask

    function automatic logic [IDX_W-1:0] pick_block();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return IDX_W'($urandom_range(0, 4095));
        if (roll < 80) return IDX_W'($urandom_range(0, 127));     // low blocks, often used
        return IDX_W'($urandom_range(3968, 4095));                // top four words of the map
    endfunction

    function automatic logic [CNT_W-1:0] pick_reserved(int phase);
        case (phase % 4)
            0:       return CNT_W'($urandom_range(0, 8191));
            1:       return CNT_W'($urandom_range(4060, 4096));   // nearly full map
            2:       return CNT_W'($urandom_range(0, 200));
            default: return CNT_W'($urandom_range(4000, 8191));   // often beyond the map
        endcase
    endfunction

    initial begin : stimulus
        int    ph;
        int    n;
        int    roll;
        t_kind kind;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // waits out the clear pass after reset
        drain_results();

        // Directed: reset reserved count, extremes of the index, repeat marks
        send_word(KIND_ALLOC, 12'd0);
        send_word(KIND_ALLOC, 12'hFFF);
        send_word(KIND_MARK, 12'hFFF);
        send_word(KIND_MARK, 12'hFFF);      // already used
        send_word(KIND_MARK, 12'd0);        // already used by the first allocate
        send_word(KIND_NONE, 12'hFFF);      // unused kind
        send_word(KIND_FORMAT, 12'd0);
        send_word(KIND_ALLOC, 12'd0);
        send_word(KIND_MARK, 12'd34);
        send_word(KIND_ALLOC, 12'd0);
        send_word(KIND_MARK, 12'h7FF);
        send_word(KIND_MARK, 12'hAAA);
        send_word(KIND_MARK, 12'h555);
        // whole map reserved: allocate must fail
        write_reserved(13'd4096);
        send_word(KIND_FORMAT, 12'hFFF);
        send_word(KIND_ALLOC, 12'd0);
        send_word(KIND_MARK, 12'hFFF);
        send_word(KIND_NONE, 12'd0);
        // reserved count above the map saturates
        write_reserved(13'd8191);
        send_word(KIND_FORMAT, 12'd0);
        send_word(KIND_ALLOC, 12'd0);
        write_reserved(13'd0);
        send_word(KIND_FORMAT, 12'd0);
        send_word(KIND_ALLOC, 12'd0);
        // one block left: take it, then the map is full
        write_reserved(13'd4095);
        send_word(KIND_FORMAT, 12'd0);
        send_word(KIND_ALLOC, 12'd0);
        send_word(KIND_ALLOC, 12'd0);

        // Random phases: new reserved count, format, then a mix of requests
        for (ph = 0; ph < PHASES; ph++) begin
            write_reserved(pick_reserved(ph));
            burst = (ph % 3 == 1);
            send_word(KIND_FORMAT, IDX_W'($urandom_range(0, 4095)));
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (n % 25 == 0 && ph % 3 != 1)
                    burst = ($urandom_range(0, 9) < 3);
                // sender pauses until all results are in
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                roll = $urandom_range(0, 99);
                if (roll < 50)      kind = KIND_ALLOC;
                else if (roll < 95) kind = KIND_MARK;
                else if (roll < 97) kind = KIND_FORMAT;
                else                kind = KIND_NONE;
                send_word(kind, (kind == KIND_MARK) ? pick_block()
                                                    : IDX_W'($urandom_range(0, 4095)));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            sb.report("requests left without a result word", sb.pending_results.size(), 0);

        $display("summary: %0d allocate, %0d mark, %0d format, %0d unused-kind words; %0d checked",
                 sb.kind_seen[KIND_ALLOC], sb.kind_seen[KIND_MARK],
                 sb.kind_seen[KIND_FORMAT], sb.kind_seen[KIND_NONE], sb.results_seen);
        $display("summary: %0d allocations refused on a full map, %0d reserved-count settings",
                 sb.full_refusals, settings_used);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: block_bitmap_allocator_unit.f
sv/bba_pkg.sv
sv/bba_map_ram.sv
sv/bba_ctrl.sv
sv/block_bitmap_allocator_unit.sv
sv/bba_chk.sv
dv/tb.sv
